// ----- hw/rtl/qknob_pkg.sv -----
// types, constants and helpers shared by the quadrature knob decoder
package qknob_pkg;

  localparam int unsigned TimeBits = 10;
  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  localparam logic [TimeBits-1:0] DebounceReset = TimeBits'(50);
  localparam logic [TimeBits-1:0] LockoutReset  = TimeBits'(150);

  localparam int unsigned CfgWidth = 10;

  typedef enum logic [2:0] {
    KIND_ENC_SAMPLE = 3'd0,
    KIND_TICK       = 3'd1,
    KIND_HOST_READ  = 3'd2,
    KIND_POS_RESET  = 3'd3,
    KIND_POS_SET    = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_LOCKOUT  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         enc_ab;
    logic               button_raw;
    logic signed [15:0] new_position;
  } in_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic signed [7:0]  delta;
    logic               button;
  } out_t;

  typedef struct packed {
    logic [TimeBits-1:0] debounce_ms;
    logic [TimeBits-1:0] lockout_ms;
  } cfg_t;

  // gray code transition table: previous ab in the high bits, new ab in the low bits
  function automatic logic signed [1:0] step_of(input logic [1:0] prev_ab,
                                                 input logic [1:0] ab);
    logic signed [1:0] dir;
    case ({prev_ab, ab})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = -2'sd1;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = 2'sd1;
      default:                            dir = 2'sd0;
    endcase
    return dir;
  endfunction

  function automatic logic [TimeBits-1:0] time_inc(input logic [TimeBits-1:0] t);
    return (t == TimeMax) ? TimeMax : t + TimeBits'(1);
  endfunction

endpackage

// ----- hw/rtl/qknob_core.sv -----
// knob state registers and the combinational update for one input word
module qknob_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  qknob_pkg::in_t  item_i,
  input  qknob_pkg::cfg_t cfg_i,
  output qknob_pkg::out_t result_o
);

  logic [15:0]                    position_q, position_d;
  logic [7:0]                     delta_q, delta_d;
  logic signed [1:0]              half_q, half_d;
  logic [1:0]                     prev_ab_q, prev_ab_d;
  logic [qknob_pkg::TimeBits-1:0] since_rot_q, since_rot_d;
  logic [qknob_pkg::TimeBits-1:0] since_chg_q, since_chg_d;
  logic                           deb_q, deb_d;
  logic                           last_raw_q, last_raw_d;

  logic signed [1:0]              dir;
  logic signed [2:0]              half_sum;
  logic [qknob_pkg::TimeBits-1:0] rot_inc, chg_inc;
  logic                           lockout_now;

  assign dir         = qknob_pkg::step_of(prev_ab_q, item_i.enc_ab);
  assign half_sum    = 3'(half_q) + 3'(dir);
  assign rot_inc     = qknob_pkg::time_inc(since_rot_q);
  assign chg_inc     = qknob_pkg::time_inc(since_chg_q);
  assign lockout_now = since_rot_q < cfg_i.lockout_ms;

  assign result_o.position = position_q;
  assign result_o.delta    = delta_q;
  assign result_o.button   = deb_q & ~lockout_now;

  always_comb begin
    position_d  = position_q;
    delta_d     = delta_q;
    half_d      = half_q;
    prev_ab_d   = prev_ab_q;
    since_rot_d = since_rot_q;
    since_chg_d = since_chg_q;
    deb_d       = deb_q;
    last_raw_d  = last_raw_q;
    if (fire_i) begin
      unique case (item_i.kind)
        qknob_pkg::KIND_ENC_SAMPLE: begin
          prev_ab_d = item_i.enc_ab;
          if (dir != 2'sd0) begin
            since_rot_d = '0;
            // counter is now zero, so lockout holds unless its length is zero
            if (cfg_i.lockout_ms != '0) begin
              deb_d       = 1'b0;
              since_chg_d = '0;
            end
            if (half_sum >= 3'sd2) begin
              half_d     = 2'(half_sum - 3'sd2);
              position_d = position_q + 16'd1;
              delta_d    = delta_q + 8'd1;
            end else if (half_sum <= -3'sd2) begin
              half_d     = 2'(half_sum + 3'sd2);
              position_d = position_q - 16'd1;
              delta_d    = delta_q - 8'd1;
            end else begin
              half_d = 2'(half_sum);
            end
          end
        end
        qknob_pkg::KIND_TICK: begin
          since_rot_d = rot_inc;
          if (rot_inc < cfg_i.lockout_ms) begin
            deb_d       = 1'b0;
            last_raw_d  = item_i.button_raw;
            since_chg_d = '0;
          end else begin
            since_chg_d = chg_inc;
            if (item_i.button_raw != last_raw_q) begin
              last_raw_d  = item_i.button_raw;
              since_chg_d = '0;
            end
            if (since_chg_d >= cfg_i.debounce_ms) begin
              deb_d = item_i.button_raw;
            end
          end
        end
        qknob_pkg::KIND_HOST_READ: begin
          delta_d = '0;
        end
        qknob_pkg::KIND_POS_RESET: begin
          position_d = '0;
          delta_d    = '0;
        end
        qknob_pkg::KIND_POS_SET: begin
          // delta gains the move modulo 256
          delta_d    = delta_q + (item_i.new_position[7:0] - position_q[7:0]);
          position_d = item_i.new_position;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      delta_q     <= '0;
      half_q      <= '0;
      prev_ab_q   <= '0;
      since_rot_q <= '0;
      since_chg_q <= '0;
      deb_q       <= 1'b0;
      last_raw_q  <= 1'b0;
    end else begin
      position_q  <= position_d;
      delta_q     <= delta_d;
      half_q      <= half_d;
      prev_ab_q   <= prev_ab_d;
      since_rot_q <= since_rot_d;
      since_chg_q <= since_chg_d;
      deb_q       <= deb_d;
      last_raw_q  <= last_raw_d;
    end
  end

endmodule

// ----- hw/rtl/quadrature_knob_with_button.sv -----
// quadrature knob decoder with debounced button: inputs and read results are registered
// throughput one word per cycle; the input register advances whenever the result register
// is free or drained, so a host read stalls only while an earlier result waits
// reset clears position, delta, time counters and button state, restores debounce to 50
// and lockout to 150 ticks; lockout is active straight after reset
module quadrature_knob_with_button (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  qknob_pkg::in_t                 in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output qknob_pkg::out_t                out_item_o,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [qknob_pkg::CfgWidth-1:0] cfg_wdata_i
);

  logic            in_valid_q, in_valid_d;
  qknob_pkg::in_t  in_item_q, in_item_d;
  logic            out_valid_q, out_valid_d;
  qknob_pkg::out_t out_item_q, out_item_d;
  qknob_pkg::cfg_t cfg_q, cfg_d;
  qknob_pkg::out_t result;
  logic            is_read, fire;

  assign is_read    = in_item_q.kind == qknob_pkg::KIND_HOST_READ;
  // a read word only leaves the input register once the result register has room
  assign fire       = in_valid_q && (!is_read || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  qknob_core u_core (
    .clk_i,
    .rst_ni,
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      in_item_d  = in_item_i;
    end

    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire && is_read) begin
      out_valid_d = 1'b1;
      out_item_d  = result;
    end

    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qknob_pkg::CFG_DEBOUNCE: cfg_d.debounce_ms = cfg_wdata_i[qknob_pkg::TimeBits-1:0];
        qknob_pkg::CFG_LOCKOUT:  cfg_d.lockout_ms  = cfg_wdata_i[qknob_pkg::TimeBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      cfg_q.debounce_ms <= qknob_pkg::DebounceReset;
      cfg_q.lockout_ms  <= qknob_pkg::LockoutReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q  <= in_item_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
